### hw/rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

    localparam int SKT_DEPTH_DEF = 16;
    localparam int KEY_W         = 32;
    localparam int ID_W          = 16;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [ID_W-1:0]  id;
    } t_entry;

    // comparator result: stored key vs. search key
    typedef struct packed {
        logic ge;
        logic eq;
    } t_cmp;

endpackage

`default_nettype wire

### hw/rtl/skt_mem.sv
`default_nettype none

module skt_mem
    import skt_pkg::*;
#(
    parameter int DEPTH = SKT_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/skt_cmp.sv
`default_nettype none

module skt_cmp
    import skt_pkg::*;
(
    input  wire logic signed [KEY_W-1:0] i_a,
    input  wire logic signed [KEY_W-1:0] i_b,
    output t_cmp                         o_res
);

    assign o_res.ge = (i_a >= i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

`default_nettype wire

### hw/rtl/sorted_key_table_core.sv
`default_nettype none

// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: key[31:0], entry_id[47:32]; tuser: func[1:0]
// m_axis    out  tdata: found[0], status[2:1], occupancy[7:3]
//
// One transaction at a time; s_axis_tready is high only while the sequencer idles.
// Insert walks down from the top entry, shifting while key >= new key.
// Delete/lookup walk up from entry 0 through one memory read port.
// Full-table insert, empty-table insert/delete/lookup and func 3 skip the table walk.
// A result waiting on m_axis does not block the next input; reset is synchronous.

module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int DEPTH = SKT_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // key, entry_id
    input  wire logic [1:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // found, status, occupancy
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS0,
        S_DEL,
        S_LKP,
        S_RESP
    } t_state;

    t_state                  r_state,  n_state;
    logic signed [KEY_W-1:0] r_key,    n_key;
    logic [ID_W-1:0]         r_id,     n_id;
    logic [AW-1:0]           r_pidx,   n_pidx;
    logic                    r_hit,    n_hit;
    logic [CNTW-1:0]         r_count,  n_count;
    logic                    r_found,  n_found;
    t_status                 r_status, n_status;
    logic                    r_ovalid, n_ovalid;
    logic [7:0]              r_odata,  n_odata;

    logic            in_acc;
    logic            out_load;
    logic [CNTW-1:0] cnt_m1;
    logic            last;
    logic            hit_now;
    t_func           func;
    t_entry          new_ent;
    t_entry          rd_ent;
    t_cmp            cmp;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    t_entry          wdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign func          = t_func'(s_axis_tuser);
    assign cnt_m1        = r_count - CNTW'(1);
    assign last          = (CNTW'(r_pidx) == cnt_m1);
    assign new_ent.key   = r_key;
    assign new_ent.id    = r_id;
    assign out_load      = (r_state == S_RESP) && (!r_ovalid || m_axis_tready);
    assign hit_now       = r_hit || cmp.eq;

    skt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_ent)
    );

    skt_cmp u_cmp (
        .i_a   (rd_ent.key),
        .i_b   (r_key),
        .o_res (cmp)
    );

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_id     = r_id;
        n_pidx   = r_pidx;
        n_hit    = r_hit;
        n_count  = r_count;
        n_found  = r_found;
        n_status = r_status;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !m_axis_tready;
        we       = 1'b0;
        waddr    = r_pidx;
        wdata    = rd_ent;
        raddr    = '0;

        case (r_state)
            S_IDLE: begin
                n_key    = s_axis_tdata[KEY_W-1:0];
                n_id     = s_axis_tdata[KEY_W+ID_W-1:KEY_W];
                n_found  = 1'b0;
                n_status = ST_OK;
                n_hit    = 1'b0;
                n_pidx   = '0;
                if (func == FN_INSERT) begin
                    raddr = cnt_m1[AW-1:0];
                end
                if (in_acc) begin
                    case (func)
                        FN_INSERT: begin
                            if (r_count >= CNTW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (r_count == '0) begin
                                we          = 1'b1;
                                waddr       = '0;
                                wdata.key   = s_axis_tdata[KEY_W-1:0];
                                wdata.id    = s_axis_tdata[KEY_W+ID_W-1:KEY_W];
                                n_count     = CNTW'(1);
                                n_state     = S_RESP;
                            end else begin
                                n_pidx  = cnt_m1[AW-1:0];
                                n_state = S_INS;
                            end
                        end
                        FN_DELETE, FN_LOOKUP: begin
                            if (r_count == '0) begin
                                n_status = ST_MISS;
                                n_state  = S_RESP;
                            end else begin
                                n_state = (func == FN_DELETE) ? S_DEL : S_LKP;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_INS: begin
                raddr = r_pidx - AW'(1);
                we    = 1'b1;
                waddr = r_pidx + AW'(1);
                if (cmp.ge) begin
                    wdata = rd_ent;
                    if (r_pidx == '0) begin
                        n_state = S_INS0;
                    end else begin
                        n_pidx = r_pidx - AW'(1);
                    end
                end else begin
                    wdata   = new_ent;
                    n_count = r_count + CNTW'(1);
                    n_state = S_RESP;
                end
            end

            S_INS0: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = new_ent;
                n_count = r_count + CNTW'(1);
                n_state = S_RESP;
            end

            S_DEL: begin
                raddr = r_pidx + AW'(1);
                // past the match every entry moves down one place
                if (r_hit) begin
                    we    = 1'b1;
                    waddr = r_pidx - AW'(1);
                    wdata = rd_ent;
                end
                if (last) begin
                    if (hit_now) begin
                        n_count = cnt_m1;
                    end else begin
                        n_status = ST_MISS;
                    end
                    n_state = S_RESP;
                end else begin
                    n_pidx = r_pidx + AW'(1);
                    n_hit  = hit_now;
                end
            end

            S_LKP: begin
                raddr = r_pidx + AW'(1);
                if (cmp.eq) begin
                    n_found = 1'b1;
                    n_state = S_RESP;
                end else if (last) begin
                    n_status = ST_MISS;
                    n_state  = S_RESP;
                end else begin
                    n_pidx = r_pidx + AW'(1);
                end
            end

            S_RESP: begin
                if (out_load) begin
                    n_odata  = {r_count[OCC_W-1:0], r_status, r_found};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_key    <= n_key;
        r_id     <= n_id;
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_status <= n_status;
        r_odata  <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("entry count above table depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_status == ST_FULL)) |-> (r_count == CNTW'(DEPTH)))
        else $error("full status reported on a table with room");

    a_lookup_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LKP) |=> (r_count == $past(r_count)))
        else $error("lookup changed the entry count");

endmodule

`default_nettype wire

### tb/sv/sorted_key_table_checker.sv
`timescale 1ns / 1ps

module sorted_key_table_checker
    import skt_pkg::*;
#(
    parameter int DEPTH = SKT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // key[31:0], entry_id[47:32]
    input  logic [1:0]  i_s_axis_tuser,   // func[1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,   // found[0], status[2:1], occupancy[7:3]
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        logic             found;
        t_status          status;
        logic [OCC_W-1:0] occ;
    } t_reply;

    // shadow of the sorted table, ascending signed keys
    logic signed [KEY_W-1:0] tbl_key [DEPTH];
    logic        [ID_W-1:0]  tbl_id  [DEPTH];
    int                      tbl_count = 0;

    t_reply replies[$];
    int     mismatches = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int find_key(input logic signed [KEY_W-1:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic t_reply apply_table_op(input t_func fn,
                                              input logic signed [KEY_W-1:0] k,
                                              input logic [ID_W-1:0] id);
        t_reply r;
        int     pos;
        r.found  = 1'b0;
        r.status = ST_OK;
        case (fn)
            FN_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // equal keys go in front of older ones
                    pos = 0;
                    while (pos < tbl_count && tbl_key[pos] < k)
                        pos++;
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_id[i]  = tbl_id[i-1];
                    end
                    tbl_key[pos] = k;
                    tbl_id[pos]  = id;
                    tbl_count++;
                end
            end
            FN_DELETE: begin
                pos = find_key(k);
                if (pos < 0) begin
                    r.status = ST_MISS;
                end else begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_id[i]  = tbl_id[i+1];
                    end
                    tbl_count--;
                end
            end
            FN_LOOKUP: begin
                if (find_key(k) >= 0)
                    r.found = 1'b1;
                else
                    r.status = ST_MISS;
            end
            default: begin
            end
        endcase
        r.occ = OCC_W'(tbl_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            tbl_count = 0;
            replies.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                replies.push_back(apply_table_op(t_func'(i_s_axis_tuser),
                                                 i_s_axis_tdata[KEY_W-1:0],
                                                 i_s_axis_tdata[KEY_W +: ID_W]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.found  = i_m_axis_tdata[0];
                got.status = t_status'(i_m_axis_tdata[2:1]);
                got.occ    = i_m_axis_tdata[7:3];
                if (replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: found=%0b status=%0d occ=%0d",
                                 $time, got.found, got.status, got.occ);
                end else begin
                    want = replies.pop_front();
                    if (got.found !== want.found || got.status !== want.status ||
                        got.occ !== want.occ) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected found=%0b status=%0d occ=%0d,",
                                      " got found=%0b status=%0d occ=%0d"},
                                     $time, want.found, want.status, want.occ,
                                     got.found, got.status, got.occ);
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= replies.size();
    end

endmodule

### tb/sv/tb_sorted_key_table_core.sv
`timescale 1ns / 1ps

module tb_sorted_key_table_core;
    import skt_pkg::*;

    localparam int DEPTH           = SKT_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int BURST_LEN       = 40;
    localparam int POOL_N          = 12;
    localparam int QUIET_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 40;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;      // key[31:0], entry_id[47:32]
    logic [1:0]  s_axis_tuser  = FN_NOP;  // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // found[0], status[2:1], occupancy[7:3]

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // small key set so deletes and lookups hit often; extremes always present
    logic [KEY_W-1:0] key_pool [POOL_N];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_key_table_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_key_table_checker #(
        .DEPTH(DEPTH)
    ) table_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sorted_key_table_core: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // returns at the edge where the transaction is accepted
    task automatic send_op(input t_func fn, input logic [KEY_W-1:0] k,
                           input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {id, k};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic t_func pick_func(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < (filling ? 55 : 20))
            return FN_INSERT;
        if (r < 75)
            return FN_DELETE;
        if (r < 93)
            return FN_LOOKUP;
        return FN_NOP;
    endfunction

    initial begin
        t_func            fn;
        logic [KEY_W-1:0] k;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_N; i++)
            key_pool[i] = $urandom();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        send_op(FN_DELETE, 32'h0000_0000, 16'h0000);
        send_op(FN_LOOKUP, 32'h8000_0000, 16'hffff);
        send_op(FN_NOP,    32'hffff_ffff, 16'hffff);
        // fill up with extremes and duplicate keys
        send_op(FN_INSERT, 32'h7fff_ffff, 16'hffff);
        send_op(FN_INSERT, 32'h8000_0000, 16'h0000);
        send_op(FN_INSERT, 32'h0000_0000, 16'h0001);
        send_op(FN_INSERT, 32'hffff_ffff, 16'h8000);
        for (int i = 0; i < DEPTH - 4; i++)
            send_op(FN_INSERT, KEY_W'(i / 3), ID_W'($urandom()));
        // table full now
        send_op(FN_INSERT, 32'h1234_5678, 16'h5a5a);
        send_op(FN_LOOKUP, 32'h7fff_ffff, 16'h0000);
        send_op(FN_LOOKUP, 32'h0000_0100, 16'h0000);
        send_op(FN_DELETE, 32'h8000_0000, 16'h0000);
        send_op(FN_DELETE, 32'h7fff_fffe, 16'h0000);
        send_op(FN_DELETE, 32'h0000_0001, 16'h0000);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // alternate insert-heavy and delete-heavy bursts to swing between full and empty
                fn = pick_func(((n / BURST_LEN) % 2) == 0);
                if (fn == FN_INSERT || $urandom_range(99) < 85)
                    k = key_pool[$urandom_range(POOL_N - 1)];
                else
                    k = $urandom();
                send_op(fn, k, ID_W'($urandom()));
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_sorted_key_table_core: done, clean");
        else
            $display("tb_sorted_key_table_core: done, errors");
        $finish;
    end

endmodule
